// ===== design/sha2_pkg.sv =====
`timescale 1ns / 1ps
package sha2_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } sha2_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start_msg;   // load initial value into chain
    logic       mode;        // mode for start_msg
    logic       wr_byte;     // write byte into block buffer
    logic [5:0] wr_idx;
    logic [7:0] wr_data;
    logic       load_sched;  // copy chain into work regs, clear round counter
    logic       round;       // run one round
    logic       fold;        // add work regs into chain
    logic       inc_block;   // unused; blocks are counted in the controller
    logic [2:0] rd_word;     // chain word to show on the output
  } sha2_cmd_t;

  typedef struct packed {
    logic [5:0] round_idx;
    logic       rounds_done;
  } sha2_stat_t;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] IV256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] IV224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

// ===== design/sha2_datapath.sv =====
`timescale 1ns / 1ps
module sha2_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  sha2_pkg::sha2_cmd_t cmd,
  output sha2_pkg::sha2_stat_t stat,
  output logic [31:0]        chain_word
);
  import sha2_pkg::*;

  logic [31:0] chain_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r;
  logic        done_r;

  // Round function and message schedule for the current round.
  logic [31:0] wj, t1, t2, s0, s1, se, sa, ch, mj;
  always_comb begin
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]} ^ (w_r[14] >> 10);
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    wj = (rnd_r < 6'd16) ? w_r[0] : (s1 + w_r[9] + s0 + w_r[0]);
    se = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
       ^ {v_r[4][24:0], v_r[4][31:25]};
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    sa = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
       ^ {v_r[0][21:0], v_r[0][31:22]};
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1 = v_r[7] + se + ch + ROUND_K[rnd_r] + wj;
    t2 = sa + mj;
  end

  // Schedule window: w_r[0] is the word for this round, shifts by one per round.
  // Before round 16 the raw words are used; later ones are expanded in place.
  // Between compressions the window holds the block, one byte written at a time.
  always_ff @(posedge clk) begin
    if (cmd.round) begin
      for (int j = 0; j < 15; j++) begin
        w_r[j] <= w_r[j+1];
      end
      w_r[15] <= wj;
    end else if (cmd.wr_byte) begin
      w_r[cmd.wr_idx[5:2]][{~cmd.wr_idx[1:0], 3'b000} +: 8] <= cmd.wr_data;
    end
    if (cmd.load_sched) begin
      for (int j = 0; j < 8; j++) begin
        v_r[j] <= chain_r[j];
      end
    end else if (cmd.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (cmd.start_msg) begin
      for (int j = 0; j < 8; j++) begin
        chain_r[j] <= cmd.mode ? IV224[j] : IV256[j];
      end
    end else if (cmd.fold) begin
      for (int j = 0; j < 8; j++) begin
        chain_r[j] <= chain_r[j] + v_r[j];
      end
    end
  end

  // Round counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r  <= '0;
      done_r <= 1'b0;
    end else if (cmd.load_sched) begin
      rnd_r  <= '0;
      done_r <= 1'b0;
    end else if (cmd.round) begin
      rnd_r  <= rnd_r + 6'd1;
      done_r <= (rnd_r == 6'd63);
    end
  end

  assign stat.round_idx   = rnd_r;
  assign stat.rounds_done = done_r;
  assign chain_word       = chain_r[cmd.rd_word];

endmodule

// ===== design/sha2_ctrl.sv =====
`timescale 1ns / 1ps
module sha2_ctrl #(
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [7:0]           in_data_byte,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_hash_mode,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_word_index,
  output logic                 out_last,
  output sha2_pkg::sha2_cmd_t  cmd,
  input  sha2_pkg::sha2_stat_t stat
);
  import sha2_pkg::*;

  sha2_state_t state_r, state_nxt;
  logic        hmode_r, mmode_r, mmode_nxt, open_r, open_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [COUNT_BITS-1:0] blocks_r, blocks_nxt;
  logic        finishing_r, finishing_nxt, last_blk_r, last_blk_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic [5:0]  pad_idx_r, pad_idx_nxt;
  logic [2:0]  widx_r, widx_nxt;
  logic [5:0]  fill_now;
  logic [2:0]  lenb;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmode_r <= 1'b0;
    end else if (cfg_valid) begin
      hmode_r <= cfg_hash_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mmode_r <= 1'b0;
      open_r <= 1'b0;
      fill_r <= '0;
      blocks_r <= '0;
      finishing_r <= 1'b0;
      last_blk_r <= 1'b0;
      bitlen_r <= '0;
      pad_idx_r <= '0;
      widx_r <= '0;
    end else begin
      state_r <= state_nxt;
      mmode_r <= mmode_nxt;
      open_r <= open_nxt;
      fill_r <= fill_nxt;
      blocks_r <= blocks_nxt;
      finishing_r <= finishing_nxt;
      last_blk_r <= last_blk_nxt;
      bitlen_r <= bitlen_nxt;
      pad_idx_r <= pad_idx_nxt;
      widx_r <= widx_nxt;
    end
  end

  // Fill level as seen by the incoming word; a new message starts empty.
  assign fill_now = open_r ? fill_r : 6'd0;
  assign lenb = pad_idx_r[2:0];

  always_comb begin
    state_nxt = state_r;
    mmode_nxt = mmode_r;
    open_nxt = open_r;
    fill_nxt = fill_r;
    blocks_nxt = blocks_r;
    finishing_nxt = finishing_r;
    last_blk_nxt = last_blk_r;
    bitlen_nxt = bitlen_r;
    pad_idx_nxt = pad_idx_r;
    widx_nxt = widx_r;
    cmd = '0;
    cmd.mode = hmode_r;
    cmd.rd_word = widx_r;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!open_r) begin
            cmd.start_msg = 1'b1;
            mmode_nxt = hmode_r;
            open_nxt = 1'b1;
            blocks_nxt = '0;
          end
          cmd.wr_byte = 1'b1;
          cmd.wr_idx = fill_now;
          if (in_cmd == CMD_ABSORB) begin
            cmd.wr_data = in_data_byte;
            fill_nxt = fill_now + 6'd1;
            if (fill_now == 6'd63) begin
              cmd.load_sched = 1'b1;
              finishing_nxt = 1'b0;
              state_nxt = ST_ROUND;
            end
          end else begin
            cmd.wr_data = PAD_BYTE;
            bitlen_nxt = 64'({(open_r ? blocks_r : {COUNT_BITS{1'b0}}), fill_now, 3'b000});
            finishing_nxt = 1'b1;
            pad_idx_nxt = fill_now + 6'd1;
            last_blk_nxt = 1'b0;
            // The pad byte that fills the block sends it straight to compression.
            if (fill_now == 6'd63) begin
              cmd.load_sched = 1'b1;
              state_nxt = ST_ROUND;
            end else begin
              state_nxt = ST_PAD;
            end
          end
        end
      end
      // Padding fills the buffer one byte a cycle; length goes in bytes 56..63.
      ST_PAD: begin
        cmd.wr_byte = 1'b1;
        cmd.wr_idx = pad_idx_r;
        if (pad_idx_r >= 6'd56 && (last_blk_r || fill_r < 6'd56)) begin
          cmd.wr_data = bitlen_r[8*(7-lenb) +: 8];
        end else begin
          cmd.wr_data = 8'h00;
        end
        pad_idx_nxt = pad_idx_r + 6'd1;
        if (pad_idx_r == 6'd63) begin
          cmd.load_sched = 1'b1;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!stat.rounds_done && stat.round_idx == 6'd0 && pad_idx_r == 6'd0
            && finishing_r) begin
          cmd.round = 1'b1;
        end
        if (stat.rounds_done) begin
          state_nxt = ST_FOLD;
        end else begin
          cmd.round = 1'b1;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        fill_nxt = '0;
        if (!finishing_r) begin
          blocks_nxt = blocks_r + {{(COUNT_BITS-1){1'b0}}, 1'b1};
          state_nxt = ST_IDLE;
        end else if (!last_blk_r && fill_r >= 6'd56) begin
          // Length did not fit: one more block of zeros and length.
          last_blk_nxt = 1'b1;
          pad_idx_nxt = '0;
          state_nxt = ST_PAD;
        end else begin
          widx_nxt = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == (mmode_r ? 3'd6 : 3'd7)) begin
            open_nxt = 1'b0;
            fill_nxt = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_word_index = widx_r;
  assign out_last = (widx_r == (mmode_r ? 3'd6 : 3'd7));

  always_ff @(posedge clk) begin
    if (rst_n && out_valid) begin
      assert (state_r == ST_EMIT) else $error("output valid outside emit");
    end
  end

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall)
    else $error("input taken while busy");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> state_r == ST_IDLE && !open_r)
    else $error("message not closed after last word");
  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND && stat.rounds_done |=> state_r == ST_FOLD)
    else $error("fold skipped");

endmodule

// ===== design/sha256_sha224_hash_engine.sv =====
`timescale 1ns / 1ps
// SHA-256 / SHA-224 engine taking one message byte per input word. An absorb
// word is taken at once, except the byte that completes a 64-byte block, after
// which the input stalls for 64 rounds of the single round unit, a step to
// retire the last round and one fold. A finish word writes the padding one
// byte a cycle up to the end of the block, runs one or two compressions, then
// presents the digest one word a cycle while out_stall is low: eight words for
// SHA-256, seven for SHA-224. hash_mode is sampled when a message starts.
module sha256_sha224_hash_engine #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_hash_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last
);
  import sha2_pkg::*;

  sha2_cmd_t  cmd;
  sha2_stat_t stat;

  sha2_ctrl #(.COUNT_BITS(COUNT_BITS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_data_byte,
    .cfg_valid, .cfg_ready, .cfg_hash_mode, .out_valid, .out_stall,
    .out_word_index, .out_last, .cmd, .stat);

  sha2_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .chain_word(out_digest_word));

endmodule
